/* rtl/ncs_pkg.sv */
// shared constants, types and helpers of the nearest neighbour crop scaler
package ncs_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  localparam int COL_W   = 8;
  localparam int ROW_W   = 8;
  localparam int SIZE_W  = 9;
  localparam int PIX_W   = 16;
  localparam int ADDR_W  = COL_W + ROW_W;
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int PROD_W  = COL_W + SIZE_W;
  localparam int CNT_W   = $clog2(PROD_W + 1);
  localparam int IDX_W   = 3;

  localparam logic [SIZE_W-1:0] MAX_W_V = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] MAX_H_V = SIZE_W'(MAX_HEIGHT);

  localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_CROP_X     = 3'd2;
  localparam logic [IDX_W-1:0] REG_CROP_Y     = 3'd3;
  localparam logic [IDX_W-1:0] REG_CROP_W     = 3'd4;
  localparam logic [IDX_W-1:0] REG_CROP_H     = 3'd5;
  localparam logic [IDX_W-1:0] REG_DST_WIDTH  = 3'd6;
  localparam logic [IDX_W-1:0] REG_DST_HEIGHT = 3'd7;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EMIT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_DIV,
    S_ADDR,
    S_READ,
    S_RESULT
  } state_t;

  // geometry after saturation to the store size
  typedef struct packed {
    logic [SIZE_W-1:0] src_w;
    logic [SIZE_W-1:0] src_h;
    logic [COL_W-1:0]  crop_x;
    logic [ROW_W-1:0]  crop_y;
    logic [SIZE_W-1:0] crop_w;
    logic [SIZE_W-1:0] crop_h;
    logic [SIZE_W-1:0] dst_w;
    logic [SIZE_W-1:0] dst_h;
    logic              size_zero;
  } geom_t;

  function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W-1:0] v,
                                                 input logic [SIZE_W-1:0] m);
    sat_size = (v > m) ? m : v;
  endfunction

endpackage

/* rtl/nearest_neighbor_crop_scaler.sv */
// top level of the nearest neighbour crop scaler for rgb565 frames
// a load word is taken every idle cycle and written to the frame store at once
// an emit word has its result after divider load, 17 divider steps, done, clamp
// register, store read and output register; a size error goes straight to the output
// next word is taken in the cycle after the result moves to the output register
// synchronous active-low reset clears position and control; the store is not cleared
module nearest_neighbor_crop_scaler (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [31:0]                in_tdata,   // load_x, load_y, load_pixel
  input  logic                       in_tuser,   // action
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [31:0]                out_tdata,  // out_pixel, out_x, out_y
  output logic                       out_tlast,  // frame_last
  output logic                       out_tuser,  // size_error
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ncs_pkg::IDX_W-1:0]  cfg_index,
  input  logic [ncs_pkg::SIZE_W-1:0] cfg_data
);

  ncs_pkg::geom_t  geom;
  ncs_pkg::state_t state_r, state_nxt;

  logic [ncs_pkg::COL_W-1:0]  load_x;
  logic [ncs_pkg::ROW_W-1:0]  load_y;
  logic [ncs_pkg::PIX_W-1:0]  load_pixel;
  logic                       in_acc;
  logic                       ram_we;
  logic                       ram_re;
  logic [ncs_pkg::PIX_W-1:0]  ram_rdata;

  logic [ncs_pkg::COL_W-1:0]  dest_col_r;
  logic [ncs_pkg::ROW_W-1:0]  dest_row_r;
  logic [ncs_pkg::PROD_W-1:0] col_prod_r, row_prod_r;
  logic [ncs_pkg::PROD_W-1:0] col_quo, row_quo;
  logic                       col_done, row_done;
  logic [ncs_pkg::ADDR_W-1:0] addr_r;
  logic                       err_r;

  logic [ncs_pkg::PROD_W:0]   sx_full, sy_full;
  logic [ncs_pkg::COL_W-1:0]  sx;
  logic [ncs_pkg::ROW_W-1:0]  sy;
  logic                       row_end, frame_end;

  logic                       mul_en, div_start, addr_en, out_load;
  logic                       out_tvalid_r;
  logic [31:0]                out_tdata_r;
  logic                       out_tlast_r, out_tuser_r;

  assign load_x     = in_tdata[7:0];
  assign load_y     = in_tdata[15:8];
  assign load_pixel = in_tdata[31:16];
  assign in_acc     = in_tvalid && in_tready;
  assign ram_we     = in_acc && (in_tuser == ncs_pkg::ACT_LOAD);
  assign cfg_ready  = 1'b1;

  ncs_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .geom     (geom)
  );

  ncs_ram #(
    .WIDTH (ncs_pkg::PIX_W),
    .DEPTH (ncs_pkg::DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({load_y, load_x}),
    .wdata (load_pixel),
    .re    (ram_re),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  ncs_divider u_col_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (col_prod_r),
    .divisor  (geom.dst_w),
    .quotient (col_quo),
    .done     (col_done)
  );

  ncs_divider u_row_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (row_prod_r),
    .divisor  (geom.dst_h),
    .quotient (row_quo),
    .done     (row_done)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ncs_pkg::S_IDLE: begin
        if (in_acc && (in_tuser == ncs_pkg::ACT_EMIT)) begin
          state_nxt = geom.size_zero ? ncs_pkg::S_RESULT : ncs_pkg::S_START;
        end
      end
      ncs_pkg::S_START:  state_nxt = ncs_pkg::S_DIV;
      ncs_pkg::S_DIV: begin
        if (col_done) begin
          state_nxt = ncs_pkg::S_ADDR;
        end
      end
      ncs_pkg::S_ADDR:   state_nxt = ncs_pkg::S_READ;
      ncs_pkg::S_READ:   state_nxt = ncs_pkg::S_RESULT;
      ncs_pkg::S_RESULT: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = ncs_pkg::S_IDLE;
        end
      end
      default: state_nxt = ncs_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = 1'b0;
    mul_en    = 1'b0;
    div_start = 1'b0;
    addr_en   = 1'b0;
    ram_re    = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ncs_pkg::S_IDLE: begin
        in_tready = 1'b1;
        mul_en    = in_tvalid && (in_tuser == ncs_pkg::ACT_EMIT);
      end
      ncs_pkg::S_START:  div_start = 1'b1;
      ncs_pkg::S_DIV:    ;
      ncs_pkg::S_ADDR:   addr_en = 1'b1;
      ncs_pkg::S_READ:   ram_re = 1'b1;
      ncs_pkg::S_RESULT: out_load = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ncs_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // products and error flag captured as the emit word is taken
  always_ff @(posedge clk) begin
    if (mul_en) begin
      col_prod_r <= ncs_pkg::PROD_W'(dest_col_r) * ncs_pkg::PROD_W'(geom.crop_w);
      row_prod_r <= ncs_pkg::PROD_W'(dest_row_r) * ncs_pkg::PROD_W'(geom.crop_h);
      err_r      <= geom.size_zero;
    end
  end

  // crop offset and clamp to the source size
  always_comb begin
    sx_full = (ncs_pkg::PROD_W+1)'(geom.crop_x) + (ncs_pkg::PROD_W+1)'(col_quo);
    sy_full = (ncs_pkg::PROD_W+1)'(geom.crop_y) + (ncs_pkg::PROD_W+1)'(row_quo);
    if (sx_full >= (ncs_pkg::PROD_W+1)'(geom.src_w)) begin
      sx = ncs_pkg::COL_W'(geom.src_w - 1'b1);
    end else begin
      sx = sx_full[ncs_pkg::COL_W-1:0];
    end
    if (sy_full >= (ncs_pkg::PROD_W+1)'(geom.src_h)) begin
      sy = ncs_pkg::ROW_W'(geom.src_h - 1'b1);
    end else begin
      sy = sy_full[ncs_pkg::ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (addr_en) begin
      addr_r <= {sy, sx};
    end
  end

  assign row_end   = ({1'b0, dest_col_r} + 1'b1) >= geom.dst_w;
  assign frame_end = row_end && (({1'b0, dest_row_r} + 1'b1) >= geom.dst_h);

  // destination position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_col_r <= '0;
      dest_row_r <= '0;
    end else if (out_load && !err_r) begin
      if (row_end) begin
        dest_col_r <= '0;
        dest_row_r <= frame_end ? '0 : dest_row_r + 1'b1;
      end else begin
        dest_col_r <= dest_col_r + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {dest_row_r, dest_col_r, err_r ? {ncs_pkg::PIX_W{1'b0}} : ram_rdata};
      out_tlast_r <= !err_r && frame_end;
      out_tuser_r <= err_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tuser  = out_tuser_r;

  a_div_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    col_done == row_done)
    else $error("column and row dividers out of step");

  a_err_holds_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && err_r |=> $stable(dest_col_r) && $stable(dest_row_r))
    else $error("position moved on a size error");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && !err_r && frame_end |=> dest_col_r == '0 && dest_row_r == '0)
    else $error("position did not wrap at frame end");

  a_no_load_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == ncs_pkg::S_IDLE && !ram_re)
    else $error("store written while an emit is in flight");

endmodule

/* rtl/ncs_ram.sv */
// generic single write port, single read port ram with registered read
module ncs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/ncs_divider.sv */
// radix-2 restoring divider, one quotient bit per cycle
module ncs_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ncs_pkg::PROD_W-1:0] dividend,
  input  logic [ncs_pkg::SIZE_W-1:0] divisor,
  output logic [ncs_pkg::PROD_W-1:0] quotient,
  output logic                       done
);

  logic [ncs_pkg::CNT_W-1:0]  cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [ncs_pkg::PROD_W-1:0] quo_r;
  logic [ncs_pkg::SIZE_W-1:0] rem_r;
  logic [ncs_pkg::SIZE_W:0]   trial;
  logic                       ge;
  logic [ncs_pkg::SIZE_W:0]   diff;

  assign trial = {rem_r, quo_r[ncs_pkg::PROD_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= ncs_pkg::CNT_W'(ncs_pkg::PROD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == ncs_pkg::CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[ncs_pkg::PROD_W-2:0], ge};
      rem_r <= ge ? diff[ncs_pkg::SIZE_W-1:0] : trial[ncs_pkg::SIZE_W-1:0];
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

/* rtl/ncs_cfg_regs.sv */
// geometry registers with saturation and zero-size detection
module ncs_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [ncs_pkg::IDX_W-1:0]  wr_index,
  input  logic [ncs_pkg::SIZE_W-1:0] wr_data,
  output ncs_pkg::geom_t             geom
);

  logic [ncs_pkg::SIZE_W-1:0] src_w_r;
  logic [ncs_pkg::SIZE_W-1:0] src_h_r;
  logic [ncs_pkg::COL_W-1:0]  crop_x_r;
  logic [ncs_pkg::ROW_W-1:0]  crop_y_r;
  logic [ncs_pkg::SIZE_W-1:0] crop_w_r;
  logic [ncs_pkg::SIZE_W-1:0] crop_h_r;
  logic [ncs_pkg::SIZE_W-1:0] dst_w_r;
  logic [ncs_pkg::SIZE_W-1:0] dst_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r  <= ncs_pkg::SIZE_W'(256);
      src_h_r  <= ncs_pkg::SIZE_W'(256);
      crop_x_r <= '0;
      crop_y_r <= '0;
      crop_w_r <= ncs_pkg::SIZE_W'(256);
      crop_h_r <= ncs_pkg::SIZE_W'(256);
      dst_w_r  <= ncs_pkg::SIZE_W'(256);
      dst_h_r  <= ncs_pkg::SIZE_W'(256);
    end else if (wr_en) begin
      case (wr_index)
        ncs_pkg::REG_SRC_WIDTH:  src_w_r  <= wr_data;
        ncs_pkg::REG_SRC_HEIGHT: src_h_r  <= wr_data;
        ncs_pkg::REG_CROP_X:     crop_x_r <= wr_data[ncs_pkg::COL_W-1:0];
        ncs_pkg::REG_CROP_Y:     crop_y_r <= wr_data[ncs_pkg::ROW_W-1:0];
        ncs_pkg::REG_CROP_W:     crop_w_r <= wr_data;
        ncs_pkg::REG_CROP_H:     crop_h_r <= wr_data;
        ncs_pkg::REG_DST_WIDTH:  dst_w_r  <= wr_data;
        ncs_pkg::REG_DST_HEIGHT: dst_h_r  <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    geom.src_w  = ncs_pkg::sat_size(src_w_r, ncs_pkg::MAX_W_V);
    geom.src_h  = ncs_pkg::sat_size(src_h_r, ncs_pkg::MAX_H_V);
    geom.crop_x = crop_x_r;
    geom.crop_y = crop_y_r;
    geom.crop_w = ncs_pkg::sat_size(crop_w_r, ncs_pkg::MAX_W_V);
    geom.crop_h = ncs_pkg::sat_size(crop_h_r, ncs_pkg::MAX_H_V);
    geom.dst_w  = ncs_pkg::sat_size(dst_w_r, ncs_pkg::MAX_W_V);
    geom.dst_h  = ncs_pkg::sat_size(dst_h_r, ncs_pkg::MAX_H_V);
    geom.size_zero = (src_w_r == '0) || (src_h_r == '0) || (crop_w_r == '0) ||
                     (crop_h_r == '0) || (dst_w_r == '0) || (dst_h_r == '0);
  end

endmodule
